// File: rtl/gne_pkg.sv
// gne_pkg: shared types, sizes and gate evaluation for the gate netlist evaluator
// used by gne_gate_mem and gate_netlist_evaluator; depends on nothing
`timescale 1ns / 1ps

package gne_pkg;

    localparam int GATES   = 64;
    localparam int NODES   = 32;
    localparam int ADDR_W  = (GATES > 1) ? $clog2(GATES) : 1;
    localparam int COUNT_W = $clog2(GATES + 1);
    localparam int IDX_W   = 5;
    localparam int ALL_W   = 32;
    localparam int GLD_W   = 7;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SET  = 2'd1,
        OP_PASS = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        GT_AND  = 3'd0,
        GT_OR   = 3'd1,
        GT_NAND = 3'd2,
        GT_NOR  = 3'd3,
        GT_XOR  = 3'd4,
        GT_XNOR = 3'd5,
        GT_NOT  = 3'd6
    } gate_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]       gate_type;
        logic [IDX_W-1:0] node_a;
        logic [IDX_W-1:0] node_b;
        logic [IDX_W-1:0] node_out;
    } gate_entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        gate_entry_t       wdata;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // node index at or above NODES reads as zero
    function automatic logic node_get(input logic [NODES-1:0] vals,
                                      input logic [IDX_W-1:0] idx);
        logic r;
        r = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            if (int'(idx) == i) begin
                r = vals[i];
            end
        end
        return r;
    endfunction

    // writes beyond NODES are dropped
    function automatic logic [NODES-1:0] node_put(input logic [NODES-1:0] vals,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic bit_val);
        logic [NODES-1:0] r;
        r = vals;
        for (int i = 0; i < NODES; i++) begin
            if (int'(idx) == i) begin
                r[i] = bit_val;
            end
        end
        return r;
    endfunction

    // returns {write enable, result}; unused type leaves the node alone
    function automatic logic [1:0] gate_eval(input logic [2:0] gtype,
                                             input logic a,
                                             input logic b);
        logic [1:0] r;
        case (gate_t'(gtype))
            GT_AND:  r = {1'b1, a & b};
            GT_OR:   r = {1'b1, a | b};
            GT_NAND: r = {1'b1, ~(a & b)};
            GT_NOR:  r = {1'b1, ~(a | b)};
            GT_XOR:  r = {1'b1, a ^ b};
            GT_XNOR: r = {1'b1, ~(a ^ b)};
            GT_NOT:  r = {1'b1, ~a};
            default: r = 2'b00;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/gne_gate_mem.sv
// gne_gate_mem: gate table storage, one write port and one registered read port
// depends on gne_pkg
`timescale 1ns / 1ps

module gne_gate_mem
    import gne_pkg::*;
(
    input  logic        aclk,
    input  mem_req_t    req,
    output gate_entry_t rdata
);

    gate_entry_t mem [GATES];
    gate_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/gate_netlist_evaluator.sv
// gate_netlist_evaluator: top level, command decode, pass sequencer and result register
// depends on gne_pkg and gne_gate_mem
`timescale 1ns / 1ps
//
// channel   dir  bits               contents
// s_axis    in   tdata 24, tuser 2  gate fields and watch node; tuser carries op
// m_axis    out  tdata 48           watch value, node vector, gate count, full flag
//
// load, set and no-op items: result register loaded from the result state, then s_tready back
// a pass: entries from zero up to gates_loaded, one gate per cycle from the read port
// s_tready is high only while the sequencer is idle; the result state waits for a free
// output register, so a stalled result holds off the transaction after the one just taken
// reset clears node values and gate count; table entries past the count are never evaluated

module gate_netlist_evaluator
    import gne_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] gate_type, [7:3] node_a, [12:8] node_b, [17:13] node_out,
    // [18] value, [23:19] watch_node
    input  logic [23:0] s_tdata,
    // [1:0] op
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] watch_value, [32:1] all_values, [39:33] gates_loaded, [40] table_full, rest zero
    output logic [47:0] m_tdata
);

    state_t state_reg, state_next;

    logic [NODES-1:0]   nodes_reg, nodes_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]   watch_reg, watch_next;
    logic               full_reg, full_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;

    op_t              in_op;
    gate_entry_t      in_gate;
    logic             in_value;
    logic [IDX_W-1:0] in_watch;
    logic             s_fire;
    logic             issue;
    logic             out_load;
    logic             pass_done;
    logic             table_is_full;
    mem_req_t         mem_req;
    gate_entry_t      mem_rdata;
    logic             eval_a, eval_b;
    logic [1:0]       eval_res;
    logic [NODES+ALL_W-1:0] nodes_ext;
    logic [31:0]      count_ext;

    assign in_op             = op_t'(s_tuser);
    assign in_gate.gate_type = s_tdata[2:0];
    assign in_gate.node_a    = s_tdata[7:3];
    assign in_gate.node_b    = s_tdata[12:8];
    assign in_gate.node_out  = s_tdata[17:13];
    assign in_value          = s_tdata[18];
    assign in_watch          = s_tdata[23:19];

    assign s_fire        = s_tvalid && s_tready;
    assign table_is_full = (32'(count_reg) >= GATES);
    assign issue         = (idx_reg < count_reg);
    assign pass_done     = !issue && !rvalid_reg;
    assign out_load      = !m_tvalid_reg || m_tready;

    gne_gate_mem u_mem (
        .aclk  (aclk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // gate under evaluation sees the node vector left by the gate before it
    assign eval_a   = node_get(nodes_reg, mem_rdata.node_a);
    assign eval_b   = node_get(nodes_reg, mem_rdata.node_b);
    assign eval_res = gate_eval(mem_rdata.gate_type, eval_a, eval_b);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (in_op == OP_PASS) ? ST_PASS : ST_RESP;
                end
            end
            ST_PASS: begin
                if (pass_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        s_tready      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = count_reg[ADDR_W-1:0];
        mem_req.wdata = in_gate;
        mem_req.raddr = idx_reg[ADDR_W-1:0];
        nodes_next    = nodes_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        rvalid_next   = 1'b0;
        watch_next    = watch_reg;
        full_next     = full_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        nodes_ext     = {{ALL_W{1'b0}}, nodes_reg};
        count_ext     = 32'(count_reg);

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    watch_next = in_watch;
                    full_next  = 1'b0;
                    idx_next   = '0;
                    case (in_op)
                        OP_LOAD: begin
                            if (table_is_full) begin
                                full_next = 1'b1;
                            end else begin
                                mem_req.we = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_SET: begin
                            nodes_next = node_put(nodes_reg, in_gate.node_out, in_value);
                        end
                        default: ;
                    endcase
                end
            end
            ST_PASS: begin
                rvalid_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rvalid_reg && eval_res[1]) begin
                    nodes_next = node_put(nodes_reg, mem_rdata.node_out, eval_res[0]);
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, full_reg, count_ext[GLD_W-1:0],
                                     nodes_ext[ALL_W-1:0],
                                     node_get(nodes_reg, watch_reg)};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            nodes_reg    <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            nodes_reg    <= nodes_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rvalid_reg   <= rvalid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        watch_reg   <= watch_next;
        full_reg    <= full_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= GATES)
        else $error("gate count above table size");

    a_rvalid_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        rvalid_reg |-> (state_reg == ST_PASS))
        else $error("table read data outside a pass");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PASS) |-> (idx_reg <= count_reg))
        else $error("pass index ran past gate count");

    a_refused_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_op == OP_LOAD && table_is_full) |=> $stable(count_reg) && full_reg)
        else $error("refused load changed the count or lost the flag");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("new transaction taken before result was queued");

endmodule
